FILE: design/bcw_pkg.sv
package bcw_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int TASK_COUNT   = 16;

    localparam int VALUE_W = 64;
    localparam int TASK_W  = 4;
    localparam int CAP_W   = 5;

    localparam int BUF_AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FILL_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    localparam int WAIT_AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int WFILL_W = $clog2(TASK_COUNT + 1);

    localparam int CAP_RESET = 16;

    typedef enum logic [1:0] {
        EV_DONE   = 2'd0,
        EV_PARKED = 2'd1,
        EV_WOKEN  = 2'd2,
        EV_REJECT = 2'd3
    } t_event;

    typedef enum logic {
        FUNC_SEND = 1'b0,
        FUNC_RECV = 1'b1
    } t_func;

endpackage

FILE: design/bcw_ram.sv
module bcw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bounded_channel_with_waiters_core.sv
// Bounded message channel between tasks. Raise i_start with a send (i_func 0)
// or a receive (i_func 1) while o_busy is low; the request transfers at that
// edge. Results are registered and come out one per cycle, each marked by
// o_strobe for exactly one cycle; the receiver cannot stall them, so it must
// take every strobed result. A request yields one result, or two when a
// parked task is woken: the caller's result first, the wake second, with
// o_last high on the final one. o_busy is high in the execute state that follows a
// transfer, in which the request reads its queue heads from the ring and
// waiter memories (registered reads) and writes back; so a new request can
// follow as soon as o_busy falls, also while a wake result still goes out.
// Write the capacity register (i_cfg_we, i_cfg_data) only while idle; 0 acts
// as 1 and values above the ring depth act as the depth.
module bounded_channel_with_waiters_core
    import bcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_func,
    input  logic [TASK_W-1:0]  i_task_id,
    input  logic [VALUE_W-1:0] i_send_value,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_data,
    output logic               o_strobe,
    output logic [1:0]         o_event_res,
    output logic [TASK_W-1:0]  o_target_task,
    output logic [VALUE_W-1:0] o_delivered_value,
    output logic               o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAKE
    } t_state;

    t_state r_state;
    logic   accept;

    // request held for the execute cycle
    t_func               r_func;
    logic [TASK_W-1:0]   r_task;
    logic [VALUE_W-1:0]  r_value;

    logic [CAP_W-1:0]    r_capacity;
    logic [CMP_W-1:0]    eff_cap;

    // queue pointers and fill counts
    logic [BUF_AW-1:0]   r_ring_rd, r_ring_wr, n_ring_rd, n_ring_wr;
    logic [FILL_W-1:0]   r_ring_fill, n_ring_fill;
    logic [WAIT_AW-1:0]  r_rw_rd, r_rw_wr, n_rw_rd, n_rw_wr;
    logic [WFILL_W-1:0]  r_rw_fill, n_rw_fill;
    logic [WAIT_AW-1:0]  r_sw_rd, r_sw_wr, n_sw_rd, n_sw_wr;
    logic [WFILL_W-1:0]  r_sw_fill, n_sw_fill;

    // memory ports
    logic                        ring_we;
    logic [BUF_AW-1:0]           ring_waddr;
    logic [VALUE_W-1:0]          ring_wdata, ring_q;
    logic                        rw_we;
    logic [TASK_W-1:0]           rw_q;
    logic                        sw_we;
    logic [TASK_W+VALUE_W-1:0]   sw_q;
    logic [TASK_W-1:0]           sw_q_task;
    logic [VALUE_W-1:0]          sw_q_value;

    // result of the execute cycle
    t_event              res_event;
    logic [VALUE_W-1:0]  res_dval;
    logic                res_last;
    logic [TASK_W-1:0]   wk_task;
    logic [VALUE_W-1:0]  wk_value;

    // output and pending wake registers
    logic                r_strobe;
    t_event              r_event;
    logic [TASK_W-1:0]   r_target;
    logic [VALUE_W-1:0]  r_dval;
    logic                r_last;
    logic [TASK_W-1:0]   r_wk_task;
    logic [VALUE_W-1:0]  r_wk_value;

    function automatic logic [BUF_AW-1:0] ring_next(input logic [BUF_AW-1:0] p,
                                                    input logic [CMP_W-1:0] cap);
        logic [CMP_W:0] nxt;
        nxt = (CMP_W + 1)'(p) + (CMP_W + 1)'(1);
        return (nxt >= {1'b0, cap}) ? '0 : nxt[BUF_AW-1:0];
    endfunction

    function automatic logic [WAIT_AW-1:0] wait_next(input logic [WAIT_AW-1:0] p);
        logic [WAIT_AW:0] nxt;
        nxt = (WAIT_AW + 1)'(p) + (WAIT_AW + 1)'(1);
        return (nxt >= (WAIT_AW + 1)'(TASK_COUNT)) ? '0 : nxt[WAIT_AW-1:0];
    endfunction

    assign o_busy = (r_state == ST_EXEC);
    assign accept = i_start && !o_busy;

    // clamp capacity: zero acts as one, beyond the ring acts as the ring depth
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(BUFFER_DEPTH)) begin
            eff_cap = CMP_W'(BUFFER_DEPTH);
        end else begin
            eff_cap = CMP_W'(r_capacity);
        end
    end

    // Memories: heads are read at the transfer edge, writes land at the end
    // of the execute cycle, so a read and a write never meet on one entry.
    bcw_ram #(.WIDTH(VALUE_W), .DEPTH(BUFFER_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (accept),
        .i_raddr (r_ring_rd),
        .o_rdata (ring_q)
    );

    bcw_ram #(.WIDTH(TASK_W), .DEPTH(TASK_COUNT)) u_recv_wait (
        .i_clk   (i_clk),
        .i_we    (rw_we),
        .i_waddr (r_rw_wr),
        .i_wdata (r_task),
        .i_re    (accept),
        .i_raddr (r_rw_rd),
        .o_rdata (rw_q)
    );

    bcw_ram #(.WIDTH(TASK_W + VALUE_W), .DEPTH(TASK_COUNT)) u_send_wait (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (r_sw_wr),
        .i_wdata ({r_task, r_value}),
        .i_re    (accept),
        .i_raddr (r_sw_rd),
        .o_rdata (sw_q)
    );

    assign sw_q_task  = sw_q[TASK_W+VALUE_W-1:VALUE_W];
    assign sw_q_value = sw_q[VALUE_W-1:0];

    // Execute: decide the outcome from fill counts and the heads just read.
    always_comb begin
        n_ring_rd   = r_ring_rd;
        n_ring_wr   = r_ring_wr;
        n_ring_fill = r_ring_fill;
        n_rw_rd     = r_rw_rd;
        n_rw_wr     = r_rw_wr;
        n_rw_fill   = r_rw_fill;
        n_sw_rd     = r_sw_rd;
        n_sw_wr     = r_sw_wr;
        n_sw_fill   = r_sw_fill;
        ring_we     = 1'b0;
        ring_waddr  = r_ring_wr;
        ring_wdata  = r_value;
        rw_we       = 1'b0;
        sw_we       = 1'b0;
        res_event   = EV_DONE;
        res_dval    = '0;
        res_last    = 1'b1;
        wk_task     = rw_q;
        wk_value    = '0;
        if (r_state == ST_EXEC) begin
            if (r_func == FUNC_SEND) begin
                if (r_rw_fill != '0) begin
                    // hand the value straight to the oldest parked receiver
                    n_rw_rd   = wait_next(r_rw_rd);
                    n_rw_fill = r_rw_fill - WFILL_W'(1);
                    res_last  = 1'b0;
                    wk_task   = rw_q;
                    wk_value  = r_value;
                end else if (CMP_W'(r_ring_fill) < eff_cap) begin
                    ring_we     = 1'b1;
                    n_ring_wr   = ring_next(r_ring_wr, eff_cap);
                    n_ring_fill = r_ring_fill + FILL_W'(1);
                end else if (r_sw_fill == WFILL_W'(TASK_COUNT)) begin
                    res_event = EV_REJECT;
                end else begin
                    sw_we     = 1'b1;
                    n_sw_wr   = wait_next(r_sw_wr);
                    n_sw_fill = r_sw_fill + WFILL_W'(1);
                    res_event = EV_PARKED;
                end
            end else begin
                if (r_ring_fill != '0) begin
                    res_dval  = ring_q;
                    n_ring_rd = ring_next(r_ring_rd, eff_cap);
                    if (r_sw_fill != '0) begin
                        // refill the freed slot from the oldest parked sender
                        n_sw_rd    = wait_next(r_sw_rd);
                        n_sw_fill  = r_sw_fill - WFILL_W'(1);
                        ring_we    = 1'b1;
                        ring_wdata = sw_q_value;
                        n_ring_wr  = ring_next(r_ring_wr, eff_cap);
                        res_last   = 1'b0;
                        wk_task    = sw_q_task;
                    end else begin
                        n_ring_fill = r_ring_fill - FILL_W'(1);
                    end
                end else if (r_sw_fill != '0) begin
                    // empty ring with parked senders: take the value directly
                    n_sw_rd   = wait_next(r_sw_rd);
                    n_sw_fill = r_sw_fill - WFILL_W'(1);
                    res_dval  = sw_q_value;
                    res_last  = 1'b0;
                    wk_task   = sw_q_task;
                end else if (r_rw_fill == WFILL_W'(TASK_COUNT)) begin
                    res_event = EV_REJECT;
                end else begin
                    rw_we     = 1'b1;
                    n_rw_wr   = wait_next(r_rw_wr);
                    n_rw_fill = r_rw_fill + WFILL_W'(1);
                    res_event = EV_PARKED;
                end
            end
        end
    end

    // queue state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_W'(CAP_RESET);
            r_ring_rd   <= '0;
            r_ring_wr   <= '0;
            r_ring_fill <= '0;
            r_rw_rd     <= '0;
            r_rw_wr     <= '0;
            r_rw_fill   <= '0;
            r_sw_rd     <= '0;
            r_sw_wr     <= '0;
            r_sw_fill   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_ring_rd   <= n_ring_rd;
            r_ring_wr   <= n_ring_wr;
            r_ring_fill <= n_ring_fill;
            r_rw_rd     <= n_rw_rd;
            r_rw_wr     <= n_rw_wr;
            r_rw_fill   <= n_rw_fill;
            r_sw_rd     <= n_sw_rd;
            r_sw_wr     <= n_sw_wr;
            r_sw_fill   <= n_sw_fill;
        end
    end

    // latch the request at the transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= t_func'(i_func);
            r_task  <= i_task_id;
            r_value <= i_send_value;
        end
    end

    // Sequencer and result registers: the caller's result goes out the
    // cycle after execute, a wake follows in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_strobe <= 1'b0;
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_strobe   <= 1'b1;
                    r_event    <= res_event;
                    r_target   <= r_task;
                    r_dval     <= res_dval;
                    r_last     <= res_last;
                    r_wk_task  <= wk_task;
                    r_wk_value <= wk_value;
                    if (!res_last) begin
                        r_state <= ST_WAKE;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_WAKE: begin
                    r_strobe <= 1'b1;
                    r_event  <= EV_WOKEN;
                    r_target <= r_wk_task;
                    r_dval   <= r_wk_value;
                    r_last   <= 1'b1;
                    r_state  <= accept ? ST_EXEC : ST_IDLE;
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe          = r_strobe;
    assign o_event_res       = r_event;
    assign o_target_task     = r_target;
    assign o_delivered_value = r_dval;
    assign o_last            = r_last;

    // the caller's first result always leaves through the execute state and the result registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 r_strobe)
        else $error("no result two cycles after transfer");

    // a non-final result is followed at once by the wake
    a_wake_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_last) |=> (r_strobe && r_last && r_event == EV_WOKEN))
        else $error("wake did not follow first result");

    // parked receivers exclude buffered data and parked senders
    a_recv_wait_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rw_fill != '0) |-> (r_ring_fill == '0 && r_sw_fill == '0))
        else $error("receivers parked while data is available");

    // fill counts stay within their stores
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring_fill <= FILL_W'(BUFFER_DEPTH)) && (r_rw_fill <= WFILL_W'(TASK_COUNT))
        && (r_sw_fill <= WFILL_W'(TASK_COUNT)))
        else $error("fill count out of range");

endmodule

FILE: tb/bounded_channel_with_waiters_core_tb.sv
`timescale 1ns / 1ps

module bounded_channel_with_waiters_core_tb;
    import bcw_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 6;

    // One strobed result as the channel should report it.
    typedef struct {
        t_event             ev;
        logic [TASK_W-1:0]  target;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_outcome;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_func;
    logic [TASK_W-1:0]  i_task_id;
    logic [VALUE_W-1:0] i_send_value;
    logic               i_cfg_we;
    logic [CAP_W-1:0]   i_cfg_data;
    logic               o_strobe;
    logic [1:0]         o_event_res;
    logic [TASK_W-1:0]  o_target_task;
    logic [VALUE_W-1:0] o_delivered_value;
    logic               o_last;

    bounded_channel_with_waiters_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_func            (i_func),
        .i_task_id         (i_task_id),
        .i_send_value      (i_send_value),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_event_res       (o_event_res),
        .o_target_task     (o_target_task),
        .o_delivered_value (o_delivered_value),
        .o_last            (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Channel predictor: its own copy of the ring, both waiter FIFOs and
    // the capacity register, advanced once per accepted transfer.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0]   channel_capacity;
    logic [VALUE_W-1:0] ring_mem [BUFFER_DEPTH];
    bit                 ring_written [BUFFER_DEPTH];
    int unsigned        ring_rd, ring_wr, ring_count;
    logic [TASK_W-1:0]  rwait_ids [TASK_COUNT];
    int unsigned        rwait_rd, rwait_wr, rwait_count;
    logic [TASK_W-1:0]  swait_ids [TASK_COUNT];
    logic [VALUE_W-1:0] swait_vals [TASK_COUNT];
    int unsigned        swait_rd, swait_wr, swait_count;

    // Results still owed by the channel, oldest first.
    t_outcome pending_outcomes [$];

    int  mismatch_count;
    int  cycle_count;
    bit  idling_on;

    function automatic int unsigned eff_capacity();
        if (channel_capacity == 0) return 1;
        if (channel_capacity > BUFFER_DEPTH) return BUFFER_DEPTH;
        return channel_capacity;
    endfunction

    // Wrap against the current effective capacity, not the ring depth.
    function automatic int unsigned ring_advance(int unsigned p);
        return (p + 1 >= eff_capacity()) ? 0 : p + 1;
    endfunction

    function automatic int unsigned waiter_advance(int unsigned p);
        return (p + 1 >= TASK_COUNT) ? 0 : p + 1;
    endfunction

    function automatic void ring_put(logic [VALUE_W-1:0] v);
        ring_mem[ring_wr] = v;
        ring_written[ring_wr] = 1'b1;
        ring_wr = ring_advance(ring_wr);
        ring_count++;
    endfunction

    function automatic logic [VALUE_W-1:0] ring_take();
        logic [VALUE_W-1:0] v;
        v = ring_mem[ring_rd];
        ring_rd = ring_advance(ring_rd);
        ring_count--;
        return v;
    endfunction

    function automatic void owe_outcome(t_event ev, logic [TASK_W-1:0] target,
                                        logic [VALUE_W-1:0] value, logic last);
        t_outcome o;
        o.ev = ev;
        o.target = target;
        o.value = value;
        o.last = last;
        pending_outcomes.push_back(o);
    endfunction

    function automatic void predict_transfer(t_func fn, logic [TASK_W-1:0] id,
                                             logic [VALUE_W-1:0] val);
        logic [TASK_W-1:0]  woken;
        logic [VALUE_W-1:0] got;
        if (fn == FUNC_SEND) begin
            if (rwait_count > 0) begin
                // Hand the value straight to the oldest parked receiver.
                woken = rwait_ids[rwait_rd];
                rwait_rd = waiter_advance(rwait_rd);
                rwait_count--;
                owe_outcome(EV_DONE, id, '0, 1'b0);
                owe_outcome(EV_WOKEN, woken, val, 1'b1);
            end else if (ring_count < eff_capacity()) begin
                ring_put(val);
                owe_outcome(EV_DONE, id, '0, 1'b1);
            end else if (swait_count >= TASK_COUNT) begin
                owe_outcome(EV_REJECT, id, '0, 1'b1);
            end else begin
                swait_ids[swait_wr] = id;
                swait_vals[swait_wr] = val;
                swait_wr = waiter_advance(swait_wr);
                swait_count++;
                owe_outcome(EV_PARKED, id, '0, 1'b1);
            end
        end else begin
            if (ring_count > 0) begin
                got = ring_take();
                if (swait_count > 0) begin
                    // Refill the freed slot from the oldest parked sender.
                    woken = swait_ids[swait_rd];
                    ring_put(swait_vals[swait_rd]);
                    swait_rd = waiter_advance(swait_rd);
                    swait_count--;
                    owe_outcome(EV_DONE, id, got, 1'b0);
                    owe_outcome(EV_WOKEN, woken, '0, 1'b1);
                end else begin
                    owe_outcome(EV_DONE, id, got, 1'b1);
                end
            end else if (swait_count > 0) begin
                woken = swait_ids[swait_rd];
                got = swait_vals[swait_rd];
                swait_rd = waiter_advance(swait_rd);
                swait_count--;
                owe_outcome(EV_DONE, id, got, 1'b0);
                owe_outcome(EV_WOKEN, woken, '0, 1'b1);
            end else if (rwait_count >= TASK_COUNT) begin
                owe_outcome(EV_REJECT, id, '0, 1'b1);
            end else begin
                rwait_ids[rwait_wr] = id;
                rwait_wr = waiter_advance(rwait_wr);
                rwait_count++;
                owe_outcome(EV_PARKED, id, '0, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every strobe must match the oldest owed result.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n && o_strobe) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected result ev=%0d task=%0d value=%h",
                                          o_event_res, o_target_task, o_delivered_value));
            end else begin
                exp_o = pending_outcomes.pop_front();
                if (o_event_res !== exp_o.ev)
                    report_mismatch($sformatf("event_res exp %0d got %0d",
                                              exp_o.ev, o_event_res));
                if (o_target_task !== exp_o.target)
                    report_mismatch($sformatf("target_task exp %0d got %0d",
                                              exp_o.target, o_target_task));
                if (o_delivered_value !== exp_o.value)
                    report_mismatch($sformatf("delivered_value exp %h got %h",
                                              exp_o.value, o_delivered_value));
                if (o_last !== exp_o.last)
                    report_mismatch($sformatf("last exp %0b got %0b",
                                              exp_o.last, o_last));
            end
        end
    end

    // Hard stop if the channel hangs or never drains.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bounded_channel_with_waiters_core_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one request and hold it until the channel takes the transfer.
    task automatic send_request(t_func fn, logic [TASK_W-1:0] id,
                                logic [VALUE_W-1:0] val);
        @(negedge i_clk);
        i_start = 1'b1;
        i_func = fn;
        i_task_id = id;
        i_send_value = val;
        do @(posedge i_clk); while (o_busy);
        predict_transfer(fn, id, val);
        // Drop start at the falling edge after the transfer; the next request raises it
        // again on a later falling edge and waits out o_busy before it transfers.
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic maybe_idle();
        if (idling_on && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    // Every request yields at least one result, so an empty queue plus the
    // SETTLE_CYCLES wait means the channel is idle.
    task automatic wait_drained();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = cap;
        @(posedge i_clk);
        channel_capacity = cap;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One random request. A receive that would pop a ring slot never written
    // turns into a send instead.
    task automatic issue_random(int unsigned send_pct);
        t_func fn;
        fn = ($urandom_range(99) < send_pct) ? FUNC_SEND : FUNC_RECV;
        if (fn == FUNC_RECV && ring_count > 0 && !ring_written[ring_rd])
            fn = FUNC_SEND;
        send_request(fn, TASK_W'($urandom_range(TASK_COUNT - 1)), random_value());
    endtask

    task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned send_pct, int items);
        set_capacity(cap);
        repeat (items) begin
            maybe_idle();
            issue_random(send_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Receiver parks on an empty channel, a send wakes it, then a plain
    // ring pass with a zero value. Capacity is still at its reset value.
    task automatic test_rendezvous();
        send_request(FUNC_RECV, 4'd0, '1);
        send_request(FUNC_SEND, 4'd15, '1);
        send_request(FUNC_SEND, 4'd9, '0);
        send_request(FUNC_RECV, 4'd6, 64'h5555_aaaa_5555_aaaa);
    endtask

    // Single-slot ring: senders park behind a full ring; each receive pulls the
    // ring value, and the first two refill from the oldest parked sender.
    task automatic test_parked_senders();
        set_capacity(5'd1);
        send_request(FUNC_SEND, 4'd1, 64'h0123_4567_89ab_cdef);
        send_request(FUNC_SEND, 4'd2, 64'hfedc_ba98_7654_3210);
        send_request(FUNC_SEND, 4'd3, 64'h8000_0000_0000_0001);
        send_request(FUNC_RECV, 4'd4, '0);
        send_request(FUNC_RECV, 4'd5, '0);
        send_request(FUNC_RECV, 4'd7, '0);
    endtask

    // Shrink the capacity while the ring holds data; the read pointer wraps
    // early and the last receive picks up a stale slot.
    task automatic test_capacity_shrink();
        set_capacity(5'd31);
        send_request(FUNC_SEND, 4'd8, 64'h1111_1111_1111_1111);
        send_request(FUNC_SEND, 4'd10, 64'h2222_2222_2222_2222);
        send_request(FUNC_SEND, 4'd12, 64'h3333_3333_3333_3333);
        set_capacity(5'd2);
        send_request(FUNC_RECV, 4'd13, '0);
        send_request(FUNC_RECV, 4'd14, '0);
        send_request(FUNC_RECV, 4'd11, '0);
    endtask

    // Fill both waiter FIFOs to the brim and one past it, then drain.
    task automatic test_waiter_overflow();
        set_capacity(5'd0);
        repeat (TASK_COUNT + 1) issue_random(0);
        repeat (2 * TASK_COUNT + 2) issue_random(100);
        repeat (TASK_COUNT + 1) issue_random(0);
    endtask

    // Phases of random traffic at different capacities and send mixes;
    // each capacity write waits for the channel to go idle first.
    task automatic test_random_traffic();
        int caps [8] = '{16, 1, 31, 0, 2, 7, 5, 16};
        int pcts [8] = '{70, 55, 30, 60, 85, 15, 50, 50};
        for (int p = 0; p < 8; p++) begin
            if (p == 5) caps[p] = $urandom_range(31);
            if (p == 7) idling_on = 1'b0;
            run_phase(CAP_W'(caps[p]), pcts[p], 95);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_func = FUNC_SEND;
        i_task_id = '0;
        i_send_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        idling_on = 1'b1;
        channel_capacity = CAP_RESET;
        ring_rd = 0;
        ring_wr = 0;
        ring_count = 0;
        rwait_rd = 0;
        rwait_wr = 0;
        rwait_count = 0;
        swait_rd = 0;
        swait_wr = 0;
        swait_count = 0;
        for (int i = 0; i < BUFFER_DEPTH; i++) ring_written[i] = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_rendezvous();
        test_parked_senders();
        test_capacity_shrink();
        test_waiter_overflow();
        test_random_traffic();

        wait_drained();
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("bounded_channel_with_waiters_core_tb: clean");
        end else begin
            $display("bounded_channel_with_waiters_core_tb: errors");
        end
        $finish;
    end

endmodule

FILE: bounded_channel_with_waiters_core.f
design/bcw_pkg.sv
design/bcw_ram.sv
design/bounded_channel_with_waiters_core.sv
tb/bounded_channel_with_waiters_core_tb.sv
